### rtl/core/itd_pkg.sv
// Shared types, constants and lookup functions for the IR tag packet decoder.
// No dependencies; imported by every module of the block.
package itd_pkg;

  localparam int FRAME_BITS = 16;
  localparam int COUNT_W    = $clog2(FRAME_BITS + 1);

  // pulse length windows, in 50 us ticks
  localparam logic [15:0] HDR_MIN = 16'd40;
  localparam logic [15:0] HDR_MAX = 16'd60;
  localparam logic [15:0] BIT_MIN = 16'd9;
  localparam logic [15:0] BIT_MAX = 16'd40;
  localparam logic [15:0] ONE_MIN = 16'd21;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BITS = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // config register indexes
  localparam logic CFG_OWN_TEAM      = 1'b0;
  localparam logic CFG_FRIENDLY_FIRE = 1'b1;

  // message ids (high byte, bit 15 set)
  localparam logic [7:0] MSG_ADD_HEALTH = 8'h80;
  localparam logic [7:0] MSG_ADD_AMMO   = 8'h81;
  localparam logic [7:0] MSG_ADMIN      = 8'h83;

  // admin command codes beyond the contiguous low range
  localparam logic [7:0] CMD_LAST_LINEAR  = 8'd8;
  localparam logic [7:0] CMD_EXPLODE      = 8'd11;
  localparam logic [7:0] CMD_READY_UP     = 8'd12;
  localparam logic [7:0] CMD_FULL_HEALTH  = 8'd13;
  localparam logic [7:0] CMD_FULL_ARMOR   = 8'd15;
  localparam logic [7:0] CMD_CLEAR_SCORES = 8'd20;
  localparam logic [7:0] CMD_TEST_SENSORS = 8'd21;
  localparam logic [7:0] CMD_STUN         = 8'd22;
  localparam logic [7:0] CMD_DISARM       = 8'd23;

  // frame kinds
  localparam logic [4:0] KIND_NULL         = 5'd0;
  localparam logic [4:0] KIND_SHOT         = 5'd1;
  localparam logic [4:0] KIND_HEALTH       = 5'd2;
  localparam logic [4:0] KIND_AMMO         = 5'd3;
  localparam logic [4:0] KIND_ADMIN_FIRST  = 5'd4;
  localparam logic [4:0] KIND_EXPLODE      = 5'd13;
  localparam logic [4:0] KIND_READY_UP     = 5'd14;
  localparam logic [4:0] KIND_FULL_HEALTH  = 5'd15;
  localparam logic [4:0] KIND_FULL_ARMOR   = 5'd16;
  localparam logic [4:0] KIND_CLEAR_SCORES = 5'd17;
  localparam logic [4:0] KIND_TEST_SENSORS = 5'd18;
  localparam logic [4:0] KIND_STUN         = 5'd19;
  localparam logic [4:0] KIND_DISARM       = 5'd20;
  localparam logic [4:0] KIND_MAX          = KIND_DISARM;

  localparam logic [7:0] DAMAGE_TABLE [16] = '{
    8'd1, 8'd2, 8'd4, 8'd5, 8'd7, 8'd10, 8'd15, 8'd17,
    8'd20, 8'd25, 8'd30, 8'd35, 8'd40, 8'd50, 8'd75, 8'd100
  };

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] amount;
  } result_t;

  function automatic logic [4:0] admin_kind(input logic [7:0] cmd);
    logic [4:0] k;
    case (cmd) inside
      [8'd0:CMD_LAST_LINEAR]: k = KIND_ADMIN_FIRST + {1'b0, cmd[3:0]};
      CMD_EXPLODE:            k = KIND_EXPLODE;
      CMD_READY_UP:           k = KIND_READY_UP;
      CMD_FULL_HEALTH:        k = KIND_FULL_HEALTH;
      CMD_FULL_ARMOR:         k = KIND_FULL_ARMOR;
      CMD_CLEAR_SCORES:       k = KIND_CLEAR_SCORES;
      CMD_TEST_SENSORS:       k = KIND_TEST_SENSORS;
      CMD_STUN:               k = KIND_STUN;
      CMD_DISARM:             k = KIND_DISARM;
      default:                k = KIND_NULL;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/ir_tag_packet_decoder_unit.sv
// IR tag packet decoder: input register, header hunt / bit collector, result register.
// Throughput: one beat per cycle while the result register is empty or being read.
// The single-pass decode between the input and result registers sets that rate.
// rst (synchronous, active high) clears the hunt state, both valid flags and the
// config registers; payload registers are not reset.
module ir_tag_packet_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [15:0] pulse_ticks
  input  logic        s_tlast,    // capture_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [4:0] frame_kind, [12:5] frame_amount, [15:13] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);
  import itd_pkg::*;

  logic [1:0] own_team;
  logic       friendly_fire;

  logic        in_valid;
  logic [15:0] pulse;
  logic        last;

  phase_t               phase, phase_next;
  logic                 space_skip, space_skip_next;
  logic [COUNT_W-1:0]   bit_count, bit_count_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic                 emit;

  logic    advance;
  logic    process;
  result_t result;
  result_t out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_team      <= 2'd0;
      friendly_fire <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_TEAM:      own_team      <= cfg_data;
        CFG_FRIENDLY_FIRE: friendly_fire <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign process  = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pulse <= s_tdata;
      last  <= s_tlast;
    end
  end

  always_comb begin
    logic [COUNT_W-1:0] count_inc;
    count_inc       = bit_count + COUNT_W'(1);
    phase_next      = phase;
    space_skip_next = space_skip;
    bit_count_next  = bit_count;
    frame_bits_next = frame_bits;
    emit            = 1'b0;
    case (phase)
      PH_BITS: begin
        if (space_skip) begin
          space_skip_next = 1'b0;
        end else begin
          space_skip_next = 1'b1;
          if (pulse >= BIT_MIN && pulse <= BIT_MAX) begin
            frame_bits_next = {frame_bits[FRAME_BITS-2:0], (pulse >= ONE_MIN)};
            bit_count_next  = count_inc;
            if (count_inc >= COUNT_W'(FRAME_BITS)) begin
              emit       = 1'b1;
              phase_next = PH_DONE;
            end
          end
        end
      end
      PH_DONE: ;
      default: begin
        // hunt, also for the unused phase code
        if (pulse >= HDR_MIN && pulse <= HDR_MAX) begin
          phase_next      = PH_BITS;
          space_skip_next = 1'b1;
          bit_count_next  = '0;
          frame_bits_next = '0;
        end
      end
    endcase
    if (last) begin
      phase_next      = PH_HUNT;
      space_skip_next = 1'b0;
      bit_count_next  = '0;
      frame_bits_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      space_skip <= 1'b0;
      bit_count  <= '0;
      frame_bits <= '0;
    end else if (process) begin
      phase      <= phase_next;
      space_skip <= space_skip_next;
      bit_count  <= bit_count_next;
      frame_bits <= frame_bits_next;
    end
  end

  // classify the frame including the bit arriving this beat
  itd_classify u_classify (
    .frame         ({frame_bits[FRAME_BITS-2:0], (pulse >= ONE_MIN)}),
    .own_team      (own_team),
    .friendly_fire (friendly_fire),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= process && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      out_result <= result;
    end
  end

  assign m_tdata = {3'b000, out_result.amount, out_result.kind};

endmodule

### rtl/core/itd_classify.sv
// Frame classifier: maps a completed 16-bit frame to kind and amount.
// Depends on itd_pkg (damage table, message ids, admin command map).
module itd_classify (
  input  logic [itd_pkg::FRAME_BITS-1:0] frame,
  input  logic [1:0]                     own_team,
  input  logic                           friendly_fire,
  output itd_pkg::result_t               result
);
  import itd_pkg::*;

  logic [7:0] hi;
  logic [7:0] lo;

  assign hi = frame[15:8];
  assign lo = frame[7:0];

  always_comb begin
    result.kind   = KIND_NULL;
    result.amount = 8'd0;
    if (!hi[7]) begin
      // shot: own-team hits only count with friendly fire on
      if (lo[7:6] != own_team || friendly_fire) begin
        result.kind   = KIND_SHOT;
        result.amount = DAMAGE_TABLE[lo[5:2]];
      end
    end else begin
      case (hi)
        MSG_ADD_HEALTH: begin
          result.kind   = KIND_HEALTH;
          result.amount = lo;
        end
        MSG_ADD_AMMO: begin
          result.kind   = KIND_AMMO;
          result.amount = lo;
        end
        MSG_ADMIN: result.kind = admin_kind(lo);
        default:   result.kind = KIND_NULL;
      endcase
    end
  end

endmodule

### rtl/core/itd_checker.sv
// Port-level checker for ir_tag_packet_decoder_unit, bound to the top level.
// Depends on itd_pkg for the frame kind codes.
module itd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import itd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:0] <= KIND_MAX && m_tdata[15:13] == 3'b000)
    else $error("frame kind out of range or padding set");

  a_zero_amount: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:0] == KIND_NULL || m_tdata[4:0] >= KIND_ADMIN_FIRST)
      |-> m_tdata[12:5] == 8'd0)
    else $error("nonzero amount on null or admin frame");

  a_shot_amount: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:0] == KIND_SHOT |-> m_tdata[12:5] != 8'd0)
    else $error("shot with zero damage");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind ir_tag_packet_decoder_unit itd_checker u_itd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
